### design/binary_turing_machine_step_macros.svh
// Assertion macros for the two-symbol machine engine.
// BTMS_ASSERT checks a property on every clock edge out of reset.
// BTMS_ASSERT_NEXT checks that a condition in one cycle gives an outcome in the next.
`ifndef BINARY_TURING_MACHINE_STEP_MACROS_SVH
`define BINARY_TURING_MACHINE_STEP_MACROS_SVH
`ifndef ASSERT_OFF
`define BTMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTMS_ASSERT_NEXT(lbl, clk, rst_n, cond, outcome, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error(msg);
`else
`define BTMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTMS_ASSERT_NEXT(lbl, clk, rst_n, cond, outcome, msg)
`endif
`endif

### design/btms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btms_pkg;

    // Item field widths
    localparam int OPCODE_W   = 2;
    localparam int CARD_NUM_W = 4;
    localparam int NEXT_W     = 5;
    localparam int STATUS_W   = 3;
    localparam int WPOS_W     = 10;
    localparam int HEAD_OUT_W = 12;
    localparam int CARD_W     = 5;
    localparam int STEPS_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TLEN_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT = 2'd2;

    localparam logic [TLEN_W-1:0]  TAPE_LEN_RST   = 11'd500;
    localparam logic [STEPS_W-1:0] MAX_STEPS_RST  = 16'd1000;
    localparam logic [CARD_W-1:0]  CARD_COUNT_RST = 5'd2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STEP    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP     = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OFFTAPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCARD = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd5;

    // One card table row
    typedef struct packed {
        logic [NEXT_W-1:0] next_card;
        logic              move_right;
        logic              write_bit;
    } t_row;

    // Command from the controller to the tape
    typedef struct packed {
        logic step;
        logic restart;
        logic wr_bit;
        logic move_right;
    } t_tape_cmd;

endpackage

`default_nettype wire

### design/btms_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command item channel
interface btms_in_if import btms_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [CARD_NUM_W-1:0] card_number;
    logic                  read_case;
    logic                  write_bit;
    logic                  move_right;
    logic [NEXT_W-1:0]     next_card;

    modport source (
        output valid, opcode, card_number, read_case, write_bit, move_right, next_card,
        input  ready
    );
    modport sink (
        input  valid, opcode, card_number, read_case, write_bit, move_right, next_card,
        output ready
    );
endinterface

// Result item channel
interface btms_out_if import btms_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic                         read_bit;
    logic                         written_bit;
    logic [WPOS_W-1:0]            write_position;
    logic signed [HEAD_OUT_W-1:0] head_position;
    logic [CARD_W-1:0]            current_card;
    logic [STEPS_W-1:0]           step_count;

    modport source (
        output valid, status, read_bit, written_bit, write_position, head_position,
               current_card, step_count,
        input  ready
    );
    modport sink (
        input  valid, status, read_bit, written_bit, write_position, head_position,
               current_card, step_count,
        output ready
    );
endinterface

`default_nettype wire

### design/binary_turing_machine_step.sv
// An accepted item waits in the input register; its result goes to the result register once
// that register is free or being emptied. Throughput: one item per cycle while results are
// taken; the step path (one tape window cell, one card table row read and a head add) lies between the two.
// Reset: control, configuration (500 cells, 1000 steps, 2 cards) and run state clear at once;
// the tape reads as all zeros with no clearing pass. The card table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_turing_machine_step_macros.svh"

module binary_turing_machine_step import btms_pkg::*; #(
    parameter int TAPE_DEPTH = 1024,
    parameter int MAX_CARDS  = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    btms_in_if.sink               i_cmd,
    btms_out_if.source            o_res
);

    localparam int AW      = $clog2(TAPE_DEPTH);
    localparam int HW      = AW + 2;
    localparam int TW      = $clog2(2 * MAX_CARDS);
    localparam int LEN_RST = (int'(TAPE_LEN_RST) > TAPE_DEPTH) ? TAPE_DEPTH
                                                               : int'(TAPE_LEN_RST);
    localparam int HEAD_RST = LEN_RST / 2;

    // Configuration
    logic [TLEN_W-1:0]  r_tape_len;
    logic [STEPS_W-1:0] r_max_steps;
    logic [CARD_W-1:0]  r_card_count;

    // Run state
    logic signed [HW-1:0] r_head;
    logic [CARD_W-1:0]    r_card;
    logic [STEPS_W-1:0]   r_steps;
    logic                 r_stopped;
    t_row                 r_table [2 * MAX_CARDS];

    // Input register
    logic                  r_in_valid;
    logic [OPCODE_W-1:0]   r_in_op;
    logic [CARD_NUM_W-1:0] r_in_card_num;
    logic                  r_in_read_case;
    logic                  r_in_wbit;
    logic                  r_in_mright;
    logic [NEXT_W-1:0]     r_in_next;

    // Result register
    logic                         r_out_valid;
    logic [STATUS_W-1:0]          r_out_status;
    logic                         r_out_rd;
    logic                         r_out_wr;
    logic [WPOS_W-1:0]            r_out_wpos;
    logic signed [HEAD_OUT_W-1:0] r_out_head;
    logic [CARD_W-1:0]            r_out_card;
    logic [STEPS_W-1:0]           r_out_steps;

    // Next values
    logic signed [HW-1:0] n_head;
    logic [CARD_W-1:0]    n_card;
    logic [STEPS_W-1:0]   n_steps;
    logic                 n_stopped;
    logic [STATUS_W-1:0]  n_status;
    logic                 n_rd, n_wr;
    logic [AW-1:0]        n_wpos;

    logic                 w_go;
    logic [31:0]          w_tl32, w_len32;
    logic [HW-1:0]        w_len;
    logic signed [HW-1:0] w_len_s;
    logic                 w_on_tape, w_card_ok, w_new_on_tape, w_next_bad;
    logic                 w_rd;
    logic [31:0]          w_tidx32, w_lidx32;
    t_row                 w_row;
    logic signed [HW-1:0] w_new_head;
    logic [STEPS_W-1:0]   w_steps_inc;
    logic signed [31:0]   w_head32;
    logic [31:0]          w_wpos32;
    t_tape_cmd            w_tape_cmd;

    // Handshake: process when the result register is free or being emptied
    assign w_go        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_go;

    // Effective tape length, clamped to 1..TAPE_DEPTH
    assign w_tl32  = {21'b0, r_tape_len};
    assign w_len32 = (r_tape_len == '0) ? 32'd1
                   : (w_tl32 > 32'(TAPE_DEPTH)) ? 32'(TAPE_DEPTH) : w_tl32;
    assign w_len   = w_len32[HW-1:0];
    assign w_len_s = $signed(w_len);

    // Checks before a transition
    assign w_on_tape = !r_head[HW-1] && (r_head < w_len_s);
    assign w_card_ok = (32'(r_card) < 32'(r_card_count)) && (32'(r_card) < 32'(MAX_CARDS));

    // Table lookup and move
    assign w_tidx32    = {26'b0, r_card, w_rd};
    assign w_row       = r_table[w_tidx32[TW-1:0]];
    assign w_new_head  = w_row.move_right ? (r_head + $signed(HW'(1)))
                                          : (r_head - $signed(HW'(1)));
    assign w_steps_inc = r_steps + 16'd1;
    assign w_new_on_tape = !w_new_head[HW-1] && (w_new_head < w_len_s);
    assign w_next_bad  = (32'(w_row.next_card) > 32'(r_card_count))
                      || (32'(w_row.next_card) > 32'(MAX_CARDS));

    // Command to the tape
    assign w_tape_cmd.step       = w_go && (r_in_op == OP_STEP) && !r_stopped
                                && w_on_tape && w_card_ok;
    assign w_tape_cmd.restart    = w_go && (r_in_op == OP_RESTART);
    assign w_tape_cmd.wr_bit     = w_row.write_bit;
    assign w_tape_cmd.move_right = w_row.move_right;

    btms_tape #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_tape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_tape_cmd),
        .i_pos    (r_head[AW-1:0]),
        .o_rd_bit (w_rd)
    );

    // Per-item behavior
    always_comb begin
        n_head    = r_head;
        n_card    = r_card;
        n_steps   = r_steps;
        n_stopped = r_stopped;
        n_status  = ST_OK;
        n_rd      = 1'b0;
        n_wr      = 1'b0;
        n_wpos    = '0;
        case (r_in_op)
            OP_LOAD: begin
            end
            OP_RESTART: begin
                n_head    = $signed(w_len >> 1);
                n_card    = '0;
                n_steps   = '0;
                n_stopped = 1'b0;
            end
            OP_STEP: begin
                if (r_stopped) begin
                    n_status = ST_STOPPED;
                end else if (!w_on_tape) begin
                    n_status  = ST_OFFTAPE;
                    n_stopped = 1'b1;
                end else if (!w_card_ok) begin
                    n_status  = ST_BADCARD;
                    n_stopped = 1'b1;
                end else begin
                    n_rd    = w_rd;
                    n_wr    = w_row.write_bit;
                    n_wpos  = r_head[AW-1:0];
                    n_head  = w_new_head;
                    n_card  = w_row.next_card - 5'd1;
                    n_steps = w_steps_inc;
                    if (w_row.next_card == '0) begin
                        n_status = ST_HALTED;
                    end else if (!w_new_on_tape) begin
                        n_status = ST_OFFTAPE;
                    end else if (w_steps_inc >= r_max_steps) begin
                        n_status = ST_LIMIT;
                    end else if (w_next_bad) begin
                        n_status = ST_BADCARD;
                    end
                    n_stopped = (n_status != ST_OK);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_head32 = 32'(n_head);
    assign w_wpos32 = 32'(n_wpos);
    assign w_lidx32 = {27'b0, r_in_card_num, r_in_read_case};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_len   <= TAPE_LEN_RST;
            r_max_steps  <= MAX_STEPS_RST;
            r_card_count <= CARD_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAPE_LEN:   r_tape_len   <= i_cfg_data[TLEN_W-1:0];
                CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data[STEPS_W-1:0];
                CFG_CARD_COUNT: r_card_count <= i_cfg_data[CARD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Card table rows
    always_ff @(posedge i_clk) begin
        if (w_go && (r_in_op == OP_LOAD) && (32'(r_in_card_num) < 32'(MAX_CARDS))) begin
            r_table[w_lidx32[TW-1:0]] <= '{next_card:  r_in_next,
                                           move_right: r_in_mright,
                                           write_bit:  r_in_wbit};
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_op        <= i_cmd.opcode;
            r_in_card_num  <= i_cmd.card_number;
            r_in_read_case <= i_cmd.read_case;
            r_in_wbit      <= i_cmd.write_bit;
            r_in_mright    <= i_cmd.move_right;
            r_in_next      <= i_cmd.next_card;
        end
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= $signed(HW'(HEAD_RST));
            r_card    <= '0;
            r_steps   <= '0;
            r_stopped <= 1'b0;
        end else if (w_go) begin
            r_head    <= n_head;
            r_card    <= n_card;
            r_steps   <= n_steps;
            r_stopped <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_status <= n_status;
            r_out_rd     <= n_rd;
            r_out_wr     <= n_wr;
            r_out_wpos   <= w_wpos32[WPOS_W-1:0];
            r_out_head   <= w_head32[HEAD_OUT_W-1:0];
            r_out_card   <= n_card + 5'd1;
            r_out_steps  <= n_steps;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.read_bit       = r_out_rd;
    assign o_res.written_bit    = r_out_wr;
    assign o_res.write_position = r_out_wpos;
    assign o_res.head_position  = r_out_head;
    assign o_res.current_card   = r_out_card;
    assign o_res.step_count     = r_out_steps;

    `BTMS_ASSERT_NEXT(a_stop_latches, i_clk, i_rst_n, w_go && (n_status != ST_OK), r_stopped, "stop status without stopped flag")
    `BTMS_ASSERT_NEXT(a_stopped_frozen, i_clk, i_rst_n, w_go && (r_in_op == OP_STEP) && r_stopped, r_stopped && (r_steps == $past(r_steps)), "stopped machine advanced")
    `BTMS_ASSERT_NEXT(a_head_moves_one, i_clk, i_rst_n, w_tape_cmd.step, (r_head == $past(r_head) + 1) || (r_head == $past(r_head) - 1), "head moved by other than one")

endmodule

`default_nettype wire

### design/btms_tape.sv
`timescale 1ns / 1ps
`default_nettype none
`include "binary_turing_machine_step_macros.svh"

// Tape store: a one-bit memory plus a three-cell window around the head.
// The cell two away in the direction of travel is fetched while a step runs,
// so it is in hand when the head gets next to it. Cells outside the span
// visited since restart read as zero, so restart needs no clearing pass.
module btms_tape import btms_pkg::*; #(
    parameter int TAPE_DEPTH = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire t_tape_cmd               i_cmd,
    input  wire [$clog2(TAPE_DEPTH)-1:0] i_pos,
    output logic                         o_rd_bit
);

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int FW = AW + 2;

    localparam logic [1:0] FETCH_NONE  = 2'd0;
    localparam logic [1:0] FETCH_LEFT  = 2'd1;
    localparam logic [1:0] FETCH_RIGHT = 2'd2;

    logic          r_mem [TAPE_DEPTH];
    logic          r_mem_q;
    logic          r_win_m1, r_win_0, r_win_p1;
    logic [1:0]    r_fetch;
    logic          r_fetch_ok;
    logic          r_span_any;
    logic [AW-1:0] r_span_lo, r_span_hi;

    logic                 w_eff_m1, w_eff_p1;
    logic signed [FW-1:0] w_pos_s, w_fa;
    logic [AW-1:0]        w_fa_idx;
    logic                 w_fa_ok;

    // Window cells with a pending fetch resolved
    assign w_eff_m1 = (r_fetch == FETCH_LEFT)  ? (r_fetch_ok & r_mem_q) : r_win_m1;
    assign w_eff_p1 = (r_fetch == FETCH_RIGHT) ? (r_fetch_ok & r_mem_q) : r_win_p1;
    assign o_rd_bit = r_win_0;

    // Cell two away in the direction of travel
    assign w_pos_s  = $signed({2'b00, i_pos});
    assign w_fa     = i_cmd.move_right ? (w_pos_s + $signed(FW'(2)))
                                       : (w_pos_s - $signed(FW'(2)));
    assign w_fa_idx = w_fa[AW-1:0];
    assign w_fa_ok  = r_span_any && !w_fa[FW-1]
                   && (w_fa >= $signed({2'b00, r_span_lo}))
                   && (w_fa <= $signed({2'b00, r_span_hi}));

    // Tape memory: one write and one read per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_mem[i_pos] <= i_cmd.wr_bit;
            r_mem_q      <= r_mem[w_fa_idx];
        end
    end

    // Window, pending fetch and visited span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_win_m1   <= 1'b0;
            r_win_0    <= 1'b0;
            r_win_p1   <= 1'b0;
            r_fetch    <= FETCH_NONE;
            r_fetch_ok <= 1'b0;
            r_span_any <= 1'b0;
            r_span_lo  <= '0;
            r_span_hi  <= '0;
        end else if (i_cmd.step) begin
            if (i_cmd.move_right) begin
                r_win_m1 <= i_cmd.wr_bit;
                r_win_0  <= w_eff_p1;
                r_win_p1 <= 1'b0;
                r_fetch  <= FETCH_RIGHT;
            end else begin
                r_win_p1 <= i_cmd.wr_bit;
                r_win_0  <= w_eff_m1;
                r_win_m1 <= 1'b0;
                r_fetch  <= FETCH_LEFT;
            end
            r_fetch_ok <= w_fa_ok;
            r_span_any <= 1'b1;
            if (!r_span_any) begin
                r_span_lo <= i_pos;
                r_span_hi <= i_pos;
            end else begin
                if (i_pos < r_span_lo) r_span_lo <= i_pos;
                if (i_pos > r_span_hi) r_span_hi <= i_pos;
            end
        end
    end

    `BTMS_ASSERT(a_span_order, i_clk, i_rst_n, r_span_any |-> (r_span_lo <= r_span_hi), "tape span inverted")
    `BTMS_ASSERT(a_fetch_side, i_clk, i_rst_n, r_fetch_ok |-> (r_fetch != FETCH_NONE), "fetch valid without side")
    `BTMS_ASSERT_NEXT(a_step_span, i_clk, i_rst_n, i_cmd.step && !i_cmd.restart, r_span_any, "step left span empty")

endmodule

`default_nettype wire
